[src/hvd_pkg.sv]
// Package for the haversine distance core: widths, constants and lookup tables.
package hvd_pkg;

  localparam int unsigned STEPS    = 30;
  localparam int unsigned SQ_STEPS = 31;
  localparam int unsigned LANES    = 4;
  localparam int unsigned XW       = 34;
  localparam int unsigned ZW       = 33;
  localparam int unsigned MAGW     = 26;
  localparam int unsigned KW       = 20;
  localparam int unsigned SQW      = 62;

  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
  localparam logic [25:0] RECIP_45    = 26'd47721859;
  localparam logic [12:0] EARTH_R_KM  = 13'd6371;
  localparam logic [22:0] HALF_CIRC   = 23'd5123840;

  typedef logic [44:0][12:0] res_tab_t;

  function automatic res_tab_t mk_tab(input int unsigned mul);
    res_tab_t t;
    for (int unsigned i = 0; i < 45; i++) begin
      t[i] = 13'((i * mul + 22) / 45);
    end
    return t;
  endfunction

  localparam res_tab_t TAB_HALF = mk_tab(4096);
  localparam res_tab_t TAB_FULL = mk_tab(8192);

  localparam logic [30:0] ATAN_Q30 [STEPS] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2
  };

endpackage

[src/haversine_distance_core.sv]
// Haversine great-circle distance core: accepts one position pair per clock cycle and
// returns the distances in input order. The pipeline is built of three chains of cells:
// 30 rotation CORDIC cells (four lanes for the sines and cosines), 31 square root digit
// cells (two lanes) and 30 vectoring CORDIC cells, plus nine stages for phase conversion,
// products and scaling. The whole pipeline holds while a result waits at the output.
module haversine_distance_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [22:0]        distance_km_o
);

  localparam int unsigned LAT = 100;
  localparam int unsigned NL  = hvd_pkg::LANES;
  localparam int unsigned NS  = hvd_pkg::STEPS;
  localparam int unsigned NQ  = hvd_pkg::SQ_STEPS;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // phase conversion
  logic signed [25:0]            d_in [NL];
  logic [hvd_pkg::MAGW-1:0]      s1_mag_q [NL];
  logic [NL-1:0]                 s1_neg_q, s2_neg_q, s3_dummy;
  logic [hvd_pkg::MAGW-1:0]      s2_mag_q [NL];
  logic [hvd_pkg::KW-1:0]        s2_k_q [NL];
  logic [51:0]                   kprod [NL];
  logic [5:0]                    rem [NL];
  logic [31:0]                   qv [NL];
  logic signed [31:0]            s3_ph_q [NL];
  logic signed [31:0]            ph_r [NL];
  logic [30:0]                   s4_m_q [NL];
  logic [NL-1:0]                 s4_neg_q, s4_flip_q, s5_flip_q;
  logic [61:0]                   zprod [NL];
  logic signed [hvd_pkg::ZW-1:0] s5_z_q [NL];

  assign s3_dummy = '0;

  always_comb begin
    d_in[0] = 26'(lat_b_i) - 26'(lat_a_i);
    d_in[1] = 26'(lon_b_i) - 26'(lon_a_i);
    d_in[2] = 26'(lat_a_i);
    d_in[3] = 26'(lat_b_i);
    for (int i = 0; i < NL; i++) begin
      kprod[i] = 52'(s1_mag_q[i]) * 52'(hvd_pkg::RECIP_45);
      rem[i]   = 6'(s2_mag_q[i] - 26'(s2_k_q[i] * 26'd45));
      if (i < 2) begin
        qv[i] = (32'(s2_k_q[i]) << 12) + 32'(hvd_pkg::TAB_HALF[rem[i]]);
      end else begin
        qv[i] = (32'(s2_k_q[i]) << 13) + 32'(hvd_pkg::TAB_FULL[rem[i]]);
      end
      ph_r[i]  = s3_ph_q[i] + 32'sh8000_0000;
      zprod[i] = 62'(s4_m_q[i]) * 62'(hvd_pkg::HALF_PI_Q30) + 62'(32'h2000_0000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        s1_neg_q[i] <= d_in[i][25];
        s1_mag_q[i] <= d_in[i][25] ? 26'(-d_in[i]) : 26'(d_in[i]);
        s2_neg_q[i] <= s1_neg_q[i] | s3_dummy[i];
        s2_mag_q[i] <= s1_mag_q[i];
        s2_k_q[i]   <= kprod[i][50:31];
        s3_ph_q[i]  <= s2_neg_q[i] ? signed'(32'(0) - qv[i]) : signed'(qv[i]);
        if (s3_ph_q[i] > 32'sd1073741824 || s3_ph_q[i] < -32'sd1073741824) begin
          s4_flip_q[i] <= 1'b1;
          s4_neg_q[i]  <= ph_r[i][31];
          s4_m_q[i]    <= ph_r[i][31] ? 31'(-ph_r[i]) : 31'(ph_r[i]);
        end else begin
          s4_flip_q[i] <= 1'b0;
          s4_neg_q[i]  <= s3_ph_q[i][31];
          s4_m_q[i]    <= s3_ph_q[i][31] ? 31'(-s3_ph_q[i]) : 31'(s3_ph_q[i]);
        end
        s5_flip_q[i] <= s4_flip_q[i];
        s5_z_q[i]    <= s4_neg_q[i] ? -signed'({2'b00, zprod[i][60:30]})
                                    : signed'({2'b00, zprod[i][60:30]});
      end
    end
  end

  // sine / cosine chains
  logic signed [hvd_pkg::XW-1:0] rx [NL][NS+1];
  logic signed [hvd_pkg::XW-1:0] ry [NL][NS+1];
  logic signed [hvd_pkg::ZW-1:0] rz [NL][NS+1];
  logic [NL-1:0]                 fl_q [NS];

  for (genvar l = 0; l < NL; l++) begin : g_rl
    assign rx[l][0] = signed'(hvd_pkg::XW'(hvd_pkg::CORDIC_GAIN));
    assign ry[l][0] = '0;
    assign rz[l][0] = s5_z_q[l];
    for (genvar j = 0; j < NS; j++) begin : g_rc
      hvd_rot_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .step_i (5'(j)),
        .x_i    (rx[l][j]),
        .y_i    (ry[l][j]),
        .z_i    (rz[l][j]),
        .x_o    (rx[l][j+1]),
        .y_o    (ry[l][j+1]),
        .z_o    (rz[l][j+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= s5_flip_q;
      for (int j = 1; j < NS; j++) begin
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  // clamp, products, haversine term
  localparam logic signed [hvd_pkg::XW-1:0] ONE_X = hvd_pkg::XW'(hvd_pkg::Q30_ONE);
  logic signed [hvd_pkg::XW-1:0] sx_c [NL];
  logic signed [hvd_pkg::XW-1:0] sy_c [NL];
  logic signed [31:0]            s6_s_q [NL];
  logic signed [31:0]            s6_c_q [NL];
  logic signed [63:0]            p_cc, p_sd, p_sl, p_t, a_sum;
  logic signed [31:0]            s7_cc_q, s7_sd_q, s7_sl_q;
  logic [30:0]                   s8_a_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      sx_c[i] = (rx[i][NS] > ONE_X) ? ONE_X : ((rx[i][NS] < -ONE_X) ? -ONE_X : rx[i][NS]);
      sy_c[i] = (ry[i][NS] > ONE_X) ? ONE_X : ((ry[i][NS] < -ONE_X) ? -ONE_X : ry[i][NS]);
    end
    p_cc  = 64'(s6_c_q[2]) * 64'(s6_c_q[3]);
    p_sd  = 64'(s6_s_q[0]) * 64'(s6_s_q[0]);
    p_sl  = 64'(s6_s_q[1]) * 64'(s6_s_q[1]);
    p_t   = 64'(s7_cc_q) * 64'(s7_sl_q);
    a_sum = 64'(s7_sd_q) + (p_t >>> 30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        s6_s_q[i] <= fl_q[NS-1][i] ? 32'(-sy_c[i]) : 32'(sy_c[i]);
        s6_c_q[i] <= fl_q[NS-1][i] ? 32'(-sx_c[i]) : 32'(sx_c[i]);
      end
      s7_cc_q <= 32'(p_cc >>> 30);
      s7_sd_q <= 32'(p_sd >>> 30);
      s7_sl_q <= 32'(p_sl >>> 30);
      if (a_sum[63]) begin
        s8_a_q <= '0;
      end else if (a_sum > 64'(hvd_pkg::Q30_ONE)) begin
        s8_a_q <= hvd_pkg::Q30_ONE;
      end else begin
        s8_a_q <= a_sum[30:0];
      end
    end
  end

  // square roots of a and 1 - a
  logic [hvd_pkg::SQW-1:0] qv_c [2][NQ+1];
  logic [hvd_pkg::SQW-1:0] qr_c [2][NQ+1];

  assign qv_c[0][0] = hvd_pkg::SQW'(s8_a_q) << 30;
  assign qv_c[1][0] = hvd_pkg::SQW'(hvd_pkg::Q30_ONE - s8_a_q) << 30;
  assign qr_c[0][0] = '0;
  assign qr_c[1][0] = '0;

  for (genvar l = 0; l < 2; l++) begin : g_ql
    for (genvar j = 0; j < NQ; j++) begin : g_qc
      hvd_sqrt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .k_i   (5'(NQ - 1 - j)),
        .v_i   (qv_c[l][j]),
        .r_i   (qr_c[l][j]),
        .v_o   (qv_c[l][j+1]),
        .r_o   (qr_c[l][j+1])
      );
    end
  end

  // arctangent chain
  logic signed [hvd_pkg::XW-1:0] vx [NS+1];
  logic signed [hvd_pkg::XW-1:0] vy [NS+1];
  logic signed [hvd_pkg::ZW-1:0] vz [NS+1];

  assign vx[0] = signed'(hvd_pkg::XW'(qr_c[1][NQ]));
  assign vy[0] = signed'(hvd_pkg::XW'(qr_c[0][NQ]));
  assign vz[0] = '0;

  for (genvar j = 0; j < NS; j++) begin : g_vc
    hvd_vec_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(j)),
      .x_i    (vx[j]),
      .y_i    (vy[j]),
      .z_i    (vz[j]),
      .x_o    (vx[j+1]),
      .y_o    (vy[j+1]),
      .z_o    (vz[j+1])
    );
  end

  // scale to kilometers
  logic [30:0] hc;
  logic [43:0] dist_p;
  logic [22:0] dist_q;

  always_comb begin
    if (vz[NS][hvd_pkg::ZW-1]) begin
      hc = '0;
    end else if (vz[NS] > signed'(hvd_pkg::ZW'(hvd_pkg::HALF_PI_Q30))) begin
      hc = hvd_pkg::HALF_PI_Q30;
    end else begin
      hc = vz[NS][30:0];
    end
    dist_p = 44'(hc) * 44'(hvd_pkg::EARTH_R_KM) + 44'(32'h0010_0000);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (dist_p[43:21] > hvd_pkg::HALF_CIRC) ? hvd_pkg::HALF_CIRC : dist_p[43:21];
    end
  end

  assign distance_km_o = dist_q;

endmodule

[src/hvd_rot_cell.sv]
// One rotation-mode CORDIC cell of the sine/cosine chain.
module hvd_rot_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [4:0]                    step_i,
  input  logic signed [hvd_pkg::XW-1:0] x_i,
  input  logic signed [hvd_pkg::XW-1:0] y_i,
  input  logic signed [hvd_pkg::ZW-1:0] z_i,
  output logic signed [hvd_pkg::XW-1:0] x_o,
  output logic signed [hvd_pkg::XW-1:0] y_o,
  output logic signed [hvd_pkg::ZW-1:0] z_o
);

  logic signed [hvd_pkg::XW-1:0] x_d, y_d, x_q, y_q, dx, dy;
  logic signed [hvd_pkg::ZW-1:0] z_d, z_q, ang;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    ang = signed'({2'b00, hvd_pkg::ATAN_Q30[step_i]});
    if (!z_i[hvd_pkg::ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[src/hvd_sqrt_cell.sv]
// One digit cell of the integer square root chain.
module hvd_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [4:0]               k_i,
  input  logic [hvd_pkg::SQW-1:0]  v_i,
  input  logic [hvd_pkg::SQW-1:0]  r_i,
  output logic [hvd_pkg::SQW-1:0]  v_o,
  output logic [hvd_pkg::SQW-1:0]  r_o
);

  logic [hvd_pkg::SQW-1:0] bitv, trial, v_d, r_d, v_q, r_q;

  always_comb begin
    bitv  = hvd_pkg::SQW'(1) << {k_i, 1'b0};
    trial = r_i + bitv;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + bitv;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

[src/hvd_vec_cell.sv]
// One vectoring-mode CORDIC cell of the arctangent chain.
module hvd_vec_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [4:0]                    step_i,
  input  logic signed [hvd_pkg::XW-1:0] x_i,
  input  logic signed [hvd_pkg::XW-1:0] y_i,
  input  logic signed [hvd_pkg::ZW-1:0] z_i,
  output logic signed [hvd_pkg::XW-1:0] x_o,
  output logic signed [hvd_pkg::XW-1:0] y_o,
  output logic signed [hvd_pkg::ZW-1:0] z_o
);

  logic signed [hvd_pkg::XW-1:0] x_d, y_d, x_q, y_q, dx, dy;
  logic signed [hvd_pkg::ZW-1:0] z_d, z_q, ang;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    ang = signed'({2'b00, hvd_pkg::ATAN_Q30[step_i]});
    if (!y_i[hvd_pkg::XW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[src/hvd_chk.sv]
// Port-level checker for the haversine distance core and its bind.
module hvd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [22:0] distance_km_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(distance_km_o))
    else $error("result changed while stalled");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_km_o <= hvd_pkg::HALF_CIRC)
    else $error("distance beyond half circumference");

endmodule

bind haversine_distance_core hvd_chk u_hvd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .distance_km_o (distance_km_o)
);

[sim/haversine_distance_core_test.sv]
// Self-checking testbench for haversine_distance_core with a fixed-point distance predictor.
module haversine_distance_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE      = 64'sd1073741824;
  localparam longint HALFPI   = 64'sd1686629713;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint RADIUS   = 64'sd6371;
  localparam longint HALF_MAX = 64'sd5123840;
  localparam int     LAT_MAX  = 5898240;
  localparam int     LON_MAX  = 11796480;
  localparam int     N_RANDOM = 1730;
  localparam int     LIMIT    = 400000;

  typedef struct packed {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
  } pos_pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] lat_a_i = '0;
  logic signed [24:0] lon_a_i = '0;
  logic signed [23:0] lat_b_i = '0;
  logic signed [24:0] lon_b_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [22:0]        distance_km_o;

  pos_pair_t   pair_q[$];
  logic [22:0] dist_q[$];
  int          errors = 0;
  int          cycles = 0;
  logic        took = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  haversine_distance_core DUT (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint to_phase(longint num);
    longint unsigned m;
    longint unsigned q;
    logic [31:0]     w;
    m = (num < 0) ? -num : num;
    q = (m + 22) / 45;
    w = (num < 0) ? 32'(-q) : 32'(q);
    return longint'($signed(w));
  endfunction

  task automatic sin_cos(input longint ph, output longint s, output longint c);
    bit     flip;
    longint x, y, z, m, dx, dy;
    flip = 0;
    x = GAIN;
    y = 0;
    if (ph > ONE) begin
      ph -= 2 * ONE;
      flip = 1;
    end else if (ph < -ONE) begin
      ph += 2 * ONE;
      flip = 1;
    end
    m = (ph < 0) ? -ph : ph;
    z = (m * HALFPI + ONE / 2) >>> 30;
    if (ph < 0) z = -z;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_Q30[i]);
      end
    end
    x = (x < -ONE) ? -ONE : ((x > ONE) ? ONE : x);
    y = (y < -ONE) ? -ONE : ((y > ONE) ? ONE : y);
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint half_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_Q30[i]);
      end
    end
    return (z < 0) ? 0 : ((z > HALFPI) ? HALFPI : z);
  endfunction

  task automatic great_circle_dist(input pos_pair_t p, output logic [22:0] km);
    longint la, oa, lb, ob;
    longint s_dlat, c_dlat, s_dlon, c_dlon, s1, c1, s2, c2;
    longint cc, a, u, v, hc, d;
    la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
    sin_cos(to_phase((lb - la) * 4096), s_dlat, c_dlat);
    sin_cos(to_phase((ob - oa) * 4096), s_dlon, c_dlon);
    sin_cos(to_phase(la * 8192), s1, c1);
    sin_cos(to_phase(lb * 8192), s2, c2);
    cc = (c1 * c2) >>> 30;
    a = ((s_dlat * s_dlat) >>> 30) + ((cc * ((s_dlon * s_dlon) >>> 30)) >>> 30);
    a = (a < 0) ? 0 : ((a > ONE) ? ONE : a);
    u = int_root(longint'(a) << 30);
    v = int_root(longint'(ONE - a) << 30);
    hc = half_angle(u, v);
    d = (hc * RADIUS + (64'sd1 << 20)) >>> 21;
    if (d > HALF_MAX) d = HALF_MAX;
    km = d[22:0];
  endtask

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic pos_pair_t mk(int la, int oa, int lb, int ob);
    pos_pair_t p;
    p.lat_a = 24'(la); p.lon_a = 25'(oa); p.lat_b = 24'(lb); p.lon_b = 25'(ob);
    return p;
  endfunction

  function automatic int rnd(int hi);
    return int'($urandom_range(0, 2 * hi)) - hi;
  endfunction

  // input side: accept at rising edge, drive new item at falling edge
  always @(posedge clk_i) begin
    logic [22:0] d;
    cycles <= cycles + 1;
    took <= 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      great_circle_dist(pair_q[0], d);
      dist_q.push_back(d);
      void'(pair_q.pop_front());
      took <= 1'b1;
    end
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    int bl, gl;
    if (rst_ni && (!in_valid_i || took)) begin
      bl = burst_left;
      gl = gap_left;
      if (bl == 0 && gl == 0) begin
        bl = $urandom_range(1, 40);
        gl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gl > 0) begin
        gl--;
        in_valid_i <= 1'b0;
      end else if (pair_q.size() > 0) begin
        bl--;
        in_valid_i <= 1'b1;
        lat_a_i <= pair_q[0].lat_a;
        lon_a_i <= pair_q[0].lon_a;
        lat_b_i <= pair_q[0].lat_b;
        lon_b_i <= pair_q[0].lon_b;
      end else begin
        in_valid_i <= 1'b0;
      end
      burst_left <= bl;
      gap_left <= gl;
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // output side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_q.size() == 0) begin
        report($sformatf("unexpected distance %0d", distance_km_o));
      end else begin
        if (distance_km_o !== dist_q[0])
          report($sformatf("distance %0d, want %0d", distance_km_o, dist_q[0]));
        void'(dist_q.pop_front());
      end
    end
  end

  initial begin
    int q;
    pair_q.push_back(mk(0, 0, 0, 0));
    pair_q.push_back(mk(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
    pair_q.push_back(mk(0, 0, 0, LON_MAX));
    pair_q.push_back(mk(0, -LON_MAX, 0, 0));
    pair_q.push_back(mk(LAT_MAX, 0, -LAT_MAX, 0));
    pair_q.push_back(mk(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
    pair_q.push_back(mk(0, -LON_MAX, 0, LON_MAX));
    pair_q.push_back(mk(10 * 65536, -LON_MAX + 65536, -10 * 65536, LON_MAX - 3 * 65536));
    pair_q.push_back(mk(30 * 65536, 40 * 65536, -30 * 65536, -140 * 65536));
    pair_q.push_back(mk(LAT_MAX, 0, LAT_MAX, LON_MAX));
    pair_q.push_back(mk(-LAT_MAX, 123, -LAT_MAX, -77777));
    pair_q.push_back(mk(1, 0, 0, 0));
    pair_q.push_back(mk(0, 0, 0, -1));
    pair_q.push_back(mk(-1, -1, 1, 1));
    pair_q.push_back(mk(45 * 65536, 90 * 65536, 45 * 65536, -90 * 65536));
    pair_q.push_back(mk(51 * 65536, -65536 / 10, 40 * 65536, -74 * 65536));
    pair_q.push_back(mk(-LAT_MAX, LON_MAX, -LAT_MAX + 1, -LON_MAX));
    pair_q.push_back(mk(3123456, -8765432, -2876543, 9123456));
    for (int i = 0; i < N_RANDOM; i++) begin
      q = rnd(LAT_MAX);
      case ($urandom_range(0, 5))
        0: pair_q.push_back(mk(q, rnd(LON_MAX), q + rnd(3000),
                               rnd(LON_MAX)));
        1: pair_q.push_back(mk(q, rnd(LON_MAX), -q, rnd(LON_MAX)));
        2: pair_q.push_back(mk(q, LON_MAX - int'($urandom_range(0, 70000)), -q,
                               -LON_MAX + int'($urandom_range(0, 70000))));
        default: pair_q.push_back(mk(q, rnd(LON_MAX), rnd(LAT_MAX), rnd(LON_MAX)));
      endcase
      if (pair_q[$].lat_b > LAT_MAX || pair_q[$].lat_b < -LAT_MAX)
        pair_q[$].lat_b = 24'(q);
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pair_q.size() == 0);
    wait (dist_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
